// ----- hw/rtl/wps_pkg.sv -----
// Shared constants and the arctangent table for the waypoint steering unit.
// No dependencies.
`default_nettype none
package wps_pkg;

  localparam int unsigned MaxPoints = 256;
  localparam int unsigned SlotW     = $clog2(MaxPoints);
  localparam int unsigned CountW    = SlotW + 1;

  localparam int unsigned AngW   = 22;  // internal angles, rad * 2^16
  localparam int unsigned VecW   = 28;  // bearing rotator datapath
  localparam int unsigned SinW   = 33;  // sine rotator datapath, Q1.30 plus headroom
  localparam int unsigned CordicSteps = 16;
  localparam int unsigned SqrtSteps   = 25;

  localparam logic signed [AngW-1:0] PiQ16     = 22'sd205887;
  localparam logic signed [AngW-1:0] HalfPiQ16 = 22'sd102944;
  localparam logic signed [AngW-1:0] TwoPiQ16  = 22'sd411774;
  localparam logic signed [SinW-1:0] CordicK   = 33'sd652032874;

  localparam logic [1:0] FuncTick  = 2'd0;
  localparam logic [1:0] FuncStore = 2'd1;
  localparam logic [1:0] FuncStart = 2'd2;

  localparam logic [1:0] RegGain   = 2'd0;
  localparam logic [1:0] RegRadius = 2'd1;
  localparam logic [1:0] RegWindow = 2'd2;

  localparam logic [15:0] GainReset   = 16'd13107;
  localparam logic [15:0] RadiusReset = 16'd100;
  localparam logic [14:0] WindowReset = 15'd4096;

  function automatic logic signed [AngW-1:0] atan_tab(input logic [3:0] idx);
    logic signed [AngW-1:0] v;
    unique case (idx)
      4'd0:  v = 22'sd51472;
      4'd1:  v = 22'sd30386;
      4'd2:  v = 22'sd16055;
      4'd3:  v = 22'sd8150;
      4'd4:  v = 22'sd4091;
      4'd5:  v = 22'sd2047;
      4'd6:  v = 22'sd1024;
      4'd7:  v = 22'sd512;
      4'd8:  v = 22'sd256;
      4'd9:  v = 22'sd128;
      4'd10: v = 22'sd64;
      4'd11: v = 22'sd32;
      4'd12: v = 22'sd16;
      4'd13: v = 22'sd8;
      4'd14: v = 22'sd4;
      default: v = 22'sd2;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/waypoint_pursuit_steering_unit.sv -----
// Top level of the waypoint steering unit: waypoint memory, sequencer and datapath.
// Depends on wps_pkg.
// A control tick that reaches the steering math runs from its beat to the result through
// differences and squares (StDiff, StSqX, StSqY), an arrival compare, the bit-serial
// square root and the 16-step bearing rotator running side by side (StIter), a wrap
// state, 16 sine rotator steps and then products and saturation (StMul, StFin).
// Store, start and stop beats finish at their beat; an arrival tick ends after the compare.
// One item is worked at a time; the input takes a beat when the sequencer is idle and
// the output register is empty. The waypoint table is a 256 x 48 synchronous memory
// read at the tick beat; its entries hold nothing defined until stored.
`default_nettype none
module waypoint_pursuit_steering_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  func_i,
  input  wire logic signed [23:0] pose_x_i,
  input  wire logic signed [23:0] pose_y_i,
  input  wire logic signed [15:0] pose_heading_i,
  input  wire logic [7:0]  point_index_i,
  input  wire logic signed [23:0] point_x_i,
  input  wire logic signed [23:0] point_y_i,
  input  wire logic [8:0]  path_count_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [22:0]      linear_speed_o,
  output logic signed [15:0] turn_rate_o,
  output logic             stop_command_o
);

  localparam int unsigned AngW = wps_pkg::AngW;
  localparam int unsigned VecW = wps_pkg::VecW;
  localparam int unsigned SinW = wps_pkg::SinW;
  localparam int unsigned SlotW = wps_pkg::SlotW;
  localparam int unsigned CountW = wps_pkg::CountW;

  localparam logic [3:0] StIdle = 4'd0;
  localparam logic [3:0] StDiff = 4'd1;
  localparam logic [3:0] StSqX  = 4'd2;
  localparam logic [3:0] StSqY  = 4'd3;
  localparam logic [3:0] StCmp  = 4'd4;
  localparam logic [3:0] StIter = 4'd5;
  localparam logic [3:0] StWrap = 4'd6;
  localparam logic [3:0] StSin  = 4'd7;
  localparam logic [3:0] StMul  = 4'd8;
  localparam logic [3:0] StFin  = 4'd9;

  // configuration
  logic [15:0] gain_q, radius_q;
  logic [14:0] window_q;
  logic        cfg_wr;
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q   <= wps_pkg::GainReset;
      radius_q <= wps_pkg::RadiusReset;
      window_q <= wps_pkg::WindowReset;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        wps_pkg::RegGain:   gain_q   <= pwdata[15:0];
        wps_pkg::RegRadius: radius_q <= pwdata[15:0];
        wps_pkg::RegWindow: window_q <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      wps_pkg::RegGain:   prdata = {16'd0, gain_q};
      wps_pkg::RegRadius: prdata = {16'd0, radius_q};
      wps_pkg::RegWindow: prdata = {17'd0, window_q};
      default:            prdata = 32'd0;
    endcase
  end

  // control state
  logic [3:0]        state_q, state_d;
  logic [CountW-1:0] size_q, slot_q;
  logic              follow_q;
  logic [4:0]        cnt_q;
  logic              in_beat;

  assign in_ready_o = (state_q == StIdle) && !out_valid_o;
  assign in_beat    = in_valid_i && in_ready_o;

  // waypoint memory, {x, y}
  logic [47:0] wp_mem [wps_pkg::MaxPoints];
  logic [47:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (in_beat && func_i == wps_pkg::FuncStore) begin
      wp_mem[point_index_i[SlotW-1:0]] <= {point_x_i, point_y_i};
    end
    rd_q <= wp_mem[slot_q[SlotW-1:0]];
  end

  // datapath registers
  logic signed [23:0] px_q, py_q;
  logic signed [15:0] hd_q;
  logic signed [24:0] dx_q, dy_q;
  logic [47:0]        sqx_q, sqy_q;
  logic [31:0]        rr_q;
  logic [49:0]        sh_q;
  logic [26:0]        rem_q;
  logic [24:0]        root_q;
  logic signed [VecW-1:0] vx_q, vy_q;
  logic signed [AngW-1:0] theta_q, alpha_q, sz_q;
  logic signed [SinW-1:0] sx_q, sy_q;
  logic signed [49:0]     tprod_q;
  logic [40:0]            sprod_q;

  logic [23:0] adx, ady;
  assign adx = dx_q[24] ? 24'(-dx_q) : dx_q[23:0];
  assign ady = dy_q[24] ? 24'(-dy_q) : dy_q[23:0];

  logic [48:0] ssum;
  assign ssum = {1'b0, sqx_q} + {1'b0, sqy_q};

  // square root step
  logic [26:0] rem_n, trial;
  assign rem_n = {rem_q[24:0], sh_q[49:48]};
  assign trial = {root_q, 2'b01};

  // rotators
  logic signed [AngW-1:0] atab;
  assign atab = wps_pkg::atan_tab(cnt_q[3:0]);
  logic signed [VecW-1:0] vxs, vys;
  assign vxs = vx_q >>> cnt_q[3:0];
  assign vys = vy_q >>> cnt_q[3:0];
  logic signed [SinW-1:0] sxs, sys;
  assign sxs = sx_q >>> cnt_q[3:0];
  assign sys = sy_q >>> cnt_q[3:0];

  // wrap and quadrant fold
  logic signed [AngW-1:0] araw, awrap, ared;
  always_comb begin
    araw = theta_q - (AngW'(hd_q) <<< 3);
    if (araw > wps_pkg::PiQ16)        awrap = araw - wps_pkg::TwoPiQ16;
    else if (araw <= -wps_pkg::PiQ16) awrap = araw + wps_pkg::TwoPiQ16;
    else                              awrap = araw;
    if (awrap > wps_pkg::HalfPiQ16)        ared = wps_pkg::PiQ16 - awrap;
    else if (awrap < -wps_pkg::HalfPiQ16)  ared = -wps_pkg::PiQ16 - awrap;
    else                                   ared = awrap;
  end

  // final rounding, saturation and heading window gate
  logic signed [49:0] tsum;
  logic signed [17:0] tsh;
  logic signed [15:0] turn;
  logic [24:0]        ssh;
  logic [22:0]        speed;
  logic [AngW-1:0]    aabs;
  always_comb begin
    tsum = tprod_q + 50'sd2147483648;
    tsh  = 18'(tsum >>> 32);
    if (tsh > 18'sd16384)       turn = 16'sd16384;
    else if (tsh < -18'sd16384) turn = -16'sd16384;
    else                        turn = tsh[15:0];
    ssh  = 25'((sprod_q + 41'd32768) >> 16);
    aabs = alpha_q[AngW-1] ? AngW'(-alpha_q) : AngW'(alpha_q);
    if (aabs < {window_q, 3'b000}) begin
      speed = (ssh > 25'd8388607) ? 23'd8388607 : ssh[22:0];
    end else begin
      speed = 23'd0;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (in_beat && func_i == wps_pkg::FuncTick && slot_q != size_q && follow_q)
                state_d = StDiff;
      StDiff: state_d = StSqX;
      StSqX:  state_d = StSqY;
      StSqY:  state_d = StCmp;
      StCmp:  state_d = ({17'd0, rr_q} > ssum) ? StIdle : StIter;
      StIter: if (cnt_q == 5'(wps_pkg::SqrtSteps - 1)) state_d = StWrap;
      StWrap: state_d = StSin;
      StSin:  if (cnt_q == 5'(wps_pkg::CordicSteps - 1)) state_d = StMul;
      StMul:  state_d = StFin;
      StFin:  state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= StIdle;
      size_q         <= '0;
      slot_q         <= '0;
      follow_q       <= 1'b0;
      cnt_q          <= '0;
      out_valid_o    <= 1'b0;
      linear_speed_o <= '0;
      turn_rate_o    <= '0;
      stop_command_o <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_valid_o && out_ready_i) out_valid_o <= 1'b0;
      if (in_beat) begin
        priority if (func_i == wps_pkg::FuncStart) begin
          size_q   <= (path_count_i > 9'(wps_pkg::MaxPoints)) ?
                      CountW'(wps_pkg::MaxPoints) : path_count_i;
          slot_q   <= '0;
          follow_q <= 1'b1;
        end else if (func_i == wps_pkg::FuncTick && slot_q == size_q) begin
          follow_q       <= 1'b0;
          slot_q         <= '0;
          out_valid_o    <= 1'b1;
          linear_speed_o <= '0;
          turn_rate_o    <= '0;
          stop_command_o <= 1'b1;
        end else begin
        end
      end
      if (state_q == StCmp && {17'd0, rr_q} > ssum) slot_q <= slot_q + 1'b1;
      if (state_q == StCmp || state_q == StWrap) cnt_q <= '0;
      else if (state_q == StIter || state_q == StSin) cnt_q <= cnt_q + 1'b1;
      if (state_q == StFin) begin
        out_valid_o    <= 1'b1;
        linear_speed_o <= speed;
        turn_rate_o    <= turn;
        stop_command_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      px_q <= pose_x_i;
      py_q <= pose_y_i;
      hd_q <= pose_heading_i;
    end
    unique case (state_q)
      StDiff: begin
        dx_q <= {rd_q[47], rd_q[47:24]} - {px_q[23], px_q};
        dy_q <= {rd_q[23], rd_q[23:0]} - {py_q[23], py_q};
      end
      StSqX: sqx_q <= adx * adx;
      StSqY: begin
        sqy_q <= ady * ady;
        rr_q  <= radius_q * radius_q;
      end
      StCmp: begin
        sh_q    <= {1'b0, ssum};
        rem_q   <= '0;
        root_q  <= '0;
        theta_q <= '0;
        if (dx_q[24]) begin
          vx_q    <= -VecW'(dx_q);
          vy_q    <= -VecW'(dy_q);
          sz_q    <= dy_q[24] ? -wps_pkg::PiQ16 : wps_pkg::PiQ16;
        end else begin
          vx_q    <= VecW'(dx_q);
          vy_q    <= VecW'(dy_q);
          sz_q    <= '0;
        end
      end
      StIter: begin
        sh_q <= {sh_q[47:0], 2'b00};
        if (rem_n >= trial) begin
          rem_q  <= rem_n - trial;
          root_q <= {root_q[23:0], 1'b1};
        end else begin
          rem_q  <= rem_n;
          root_q <= {root_q[23:0], 1'b0};
        end
        if (cnt_q < 5'(wps_pkg::CordicSteps)) begin
          if (vy_q > 0) begin
            vx_q <= vx_q + vys;
            vy_q <= vy_q - vxs;
            sz_q <= sz_q + atab;
          end else begin
            vx_q <= vx_q - vys;
            vy_q <= vy_q + vxs;
            sz_q <= sz_q - atab;
          end
        end
        // zero vector keeps bearing at zero
        if (cnt_q == 5'(wps_pkg::SqrtSteps - 1)) begin
          theta_q <= (dx_q == '0 && dy_q == '0) ? '0 : sz_q;
        end
      end
      StWrap: begin
        alpha_q <= awrap;
        sz_q    <= ared;
        sx_q    <= wps_pkg::CordicK;
        sy_q    <= '0;
      end
      StSin: begin
        if (sz_q >= 0) begin
          sx_q <= sx_q - sys;
          sy_q <= sy_q + sxs;
          sz_q <= sz_q - atab;
        end else begin
          sx_q <= sx_q + sys;
          sy_q <= sy_q - sxs;
          sz_q <= sz_q + atab;
        end
      end
      StMul: begin
        tprod_q <= $signed({1'b0, gain_q}) * sy_q;
        sprod_q <= root_q * gain_q;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire
